### rtl/signed_divide_remainder_unit_defines.svh
// Shared assertion macros
`ifndef SIGNED_DIVIDE_REMAINDER_UNIT_DEFINES_SVH
`define SIGNED_DIVIDE_REMAINDER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SDRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdru_pkg.sv
package sdru_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned ByteWidth    = 8;

  typedef struct packed {
    logic valid;
    logic neg_q;
    logic neg_r;
    logic byte_mode;
  } sdru_ctrl_t;

endpackage

### rtl/sdru_in_if.sv
interface sdru_in_if import sdru_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] dividend;
  logic signed [DATA_WIDTH-1:0] divisor;
  logic                         byte_mode;

  modport source (output valid, dividend, divisor, byte_mode, input ready);
  modport sink   (input valid, dividend, divisor, byte_mode, output ready);
endinterface

### rtl/sdru_out_if.sv
interface sdru_out_if import sdru_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient;
  logic signed [DATA_WIDTH-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

### rtl/signed_divide_remainder_unit.sv
// Stages from transaction accept to result valid: operand register,
// one cell per quotient bit, output register.
// Throughput: one transaction per cycle; the whole chain advances together
// and holds while a result waits at the output.
// Reset clears the valid bits of every stage; data registers are not reset.
`include "signed_divide_remainder_unit_defines.svh"

module signed_divide_remainder_unit import sdru_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sdru_in_if.sink    in_if,
  sdru_out_if.source out_if
);

  logic                  adv;
  logic [DATA_WIDTH-1:0] a_ext, b_ext, ma_d, mb_d;

  sdru_ctrl_t            ctrl_s [DATA_WIDTH+1];
  logic [DATA_WIDTH:0]   rem_s  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] quo_s  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] num_s  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den_s  [DATA_WIDTH+1];

  sdru_ctrl_t            ctrl_d;

  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  always_comb begin
    if (in_if.byte_mode) begin
      a_ext = DATA_WIDTH'($signed(in_if.dividend[ByteWidth-1:0]));
      b_ext = DATA_WIDTH'($signed(in_if.divisor[ByteWidth-1:0]));
    end else begin
      a_ext = in_if.dividend;
      b_ext = in_if.divisor;
    end
    ma_d             = a_ext[DATA_WIDTH-1] ? (~a_ext + 1'b1) : a_ext;
    mb_d             = b_ext[DATA_WIDTH-1] ? (~b_ext + 1'b1) : b_ext;
    ctrl_d.valid     = in_if.valid;
    ctrl_d.neg_q     = a_ext[DATA_WIDTH-1] ^ b_ext[DATA_WIDTH-1];
    ctrl_d.neg_r     = a_ext[DATA_WIDTH-1];
    ctrl_d.byte_mode = in_if.byte_mode;
  end

  // operand stage
  sdru_ctrl_t            ctrl_q;
  logic [DATA_WIDTH-1:0] ma_q, mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ma_q <= ma_d;
      mb_q <= mb_d;
    end
  end

  assign ctrl_s[0] = ctrl_q;
  assign rem_s[0]  = '0;
  assign quo_s[0]  = '0;
  assign num_s[0]  = ma_q;
  assign den_s[0]  = mb_q;

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sdru_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (ctrl_s[i]),
      .rem_i  (rem_s[i]),
      .quo_i  (quo_s[i]),
      .num_i  (num_s[i]),
      .den_i  (den_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .quo_o  (quo_s[i+1]),
      .num_o  (num_s[i+1]),
      .den_o  (den_s[i+1])
    );
  end

  sdru_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .ctrl_i      (ctrl_s[DATA_WIDTH]),
    .rem_i       (rem_s[DATA_WIDTH]),
    .quo_i       (quo_s[DATA_WIDTH]),
    .valid_o     (out_if.valid),
    .quotient_o  (out_if.quotient),
    .remainder_o (out_if.remainder)
  );

  `SDRU_ASSERT_NOW(a_rem_below_div,
                   ctrl_s[DATA_WIDTH].valid && (den_s[DATA_WIDTH] != '0),
                   rem_s[DATA_WIDTH] < {1'b0, den_s[DATA_WIDTH]},
                   "final remainder not below divisor")
  `SDRU_ASSERT_NOW(a_mag_bound,
                   ctrl_q.valid && mb_q[DATA_WIDTH-1],
                   mb_q[DATA_WIDTH-2:0] == '0,
                   "divisor magnitude out of range")
  `SDRU_ASSERT_NEXT(a_chain_hold,
                    !adv,
                    $stable(ctrl_s[DATA_WIDTH]) && $stable(quo_s[DATA_WIDTH]),
                    "chain moved during stall")

endmodule

### rtl/sdru_cell.sv
module sdru_cell import sdru_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  sdru_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH:0]   rem_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] num_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  output sdru_ctrl_t            ctrl_o,
  output logic [DATA_WIDTH:0]   rem_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] num_o,
  output logic [DATA_WIDTH-1:0] den_o
);

  sdru_ctrl_t            ctrl_q;
  logic [DATA_WIDTH:0]   rem_q, rem_d, shifted;
  logic [DATA_WIDTH-1:0] quo_q, quo_d, num_q, den_q;
  logic                  fits;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_i[DATA_WIDTH-1:0], num_i[DATA_WIDTH-1]};
    fits    = shifted >= {1'b0, den_i};
    rem_d   = fits ? (shifted - {1'b0, den_i}) : shifted;
    quo_d   = {quo_i[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      num_q <= {num_i[DATA_WIDTH-2:0], 1'b0};
      den_q <= den_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

### rtl/sdru_fix.sv
module sdru_fix import sdru_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  sdru_ctrl_t                   ctrl_i,
  input  logic [DATA_WIDTH:0]          rem_i,
  input  logic [DATA_WIDTH-1:0]        quo_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic signed [DATA_WIDTH-1:0] remainder_o
);

  logic                         valid_q;
  logic [DATA_WIDTH-1:0]        quo_s, rem_s;
  logic signed [DATA_WIDTH-1:0] quotient_d, remainder_d, quotient_q, remainder_q;

  // apply signs, then wrap and sign-extend from the active width
  always_comb begin
    quo_s = ctrl_i.neg_q ? (~quo_i + 1'b1) : quo_i;
    rem_s = ctrl_i.neg_r ? (~rem_i[DATA_WIDTH-1:0] + 1'b1) : rem_i[DATA_WIDTH-1:0];
    if (ctrl_i.byte_mode) begin
      quotient_d  = DATA_WIDTH'($signed(quo_s[ByteWidth-1:0]));
      remainder_d = DATA_WIDTH'($signed(rem_s[ByteWidth-1:0]));
    end else begin
      quotient_d  = quo_s;
      remainder_d = rem_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quotient_q  <= quotient_d;
      remainder_q <= remainder_d;
    end
  end

  assign valid_o     = valid_q;
  assign quotient_o  = quotient_q;
  assign remainder_o = remainder_q;

endmodule
